// ===== rtl/cr_interp_pkg.sv =====
// ============================================================================
// cr_interp_pkg: shared constants for the Catmull-Rom curve interpolator
// Default parameter values, the segment count register layout and the table
// of sample-position steps used to walk the spline parameter across a span.
// ============================================================================
`default_nettype none

package cr_interp_pkg;

  localparam int unsigned DEFAULT_MAX_SEGMENTS = 16;
  localparam int unsigned DEFAULT_COORD_WIDTH  = 16;

  // Segment count register.
  localparam int unsigned SEG_WIDTH = 5;
  localparam int unsigned SEG_RESET = 8;

  // Fraction bits of the spline parameter s.
  localparam int unsigned S_FRAC = 16;

  // floor(65536 / n) for n = 0 .. 31; the entry for zero is never used.
  localparam logic [16:0] SEG_STEP [32] = '{
    17'd0,    17'd65536, 17'd32768, 17'd21845, 17'd16384, 17'd13107, 17'd10922, 17'd9362,
    17'd8192, 17'd7281,  17'd6553,  17'd5957,  17'd5461,  17'd5041,  17'd4681,  17'd4369,
    17'd4096, 17'd3855,  17'd3640,  17'd3449,  17'd3276,  17'd3120,  17'd2978,  17'd2849,
    17'd2730, 17'd2621,  17'd2520,  17'd2427,  17'd2340,  17'd2259,  17'd2184,  17'd2114
  };

endpackage

`default_nettype wire

// ===== rtl/catmull_rom_curve_interpolator_unit.sv =====
// ============================================================================
// catmull_rom_curve_interpolator_unit: uniform Catmull-Rom spline generator
// Takes control points one per transfer and streams segment_count samples per
// span, evaluated in fixed point on one shared multiplier.
// ============================================================================
// Control points arrive on the slave stream; tlast marks the last point of a
// curve. For point k >= 2 the block emits the span between points k-2 and k-1;
// on the last point it also emits the closing span and then the last point
// itself, and a lone point comes back unchanged. For each sample and each
// coordinate the sequencer loads the cubic coefficient, takes three Horner
// products in two multiplier passes each (low and high half of the
// accumulator times s), and rounds and saturates; it then hands the sample to
// the output register. An item that produces nothing leaves the block idle.
// The slave side is not ready while an item is being worked on. The output
// sits in a register so the sequencer keeps computing while a sample waits.
// The segment count register may only be written while the block is idle.
`default_nettype none

module catmull_rom_curve_interpolator_unit #(
  parameter int unsigned MAX_SEGMENTS = cr_interp_pkg::DEFAULT_MAX_SEGMENTS,
  parameter int unsigned COORD_WIDTH  = cr_interp_pkg::DEFAULT_COORD_WIDTH,
  localparam int unsigned DataWidth   = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Segment count register write.
  input  logic                                 cfg_we_i,
  input  logic [cr_interp_pkg::SEG_WIDTH-1:0]  cfg_data_i,
  // Control points.
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [DataWidth-1:0]                 s_axis_tdata,  // point_x, point_y
  input  logic                                 s_axis_tlast,  // final_point
  // Curve samples.
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [DataWidth-1:0]                 m_axis_tdata,  // curve_x, curve_y
  output logic                                 m_axis_tlast   // run_end
);

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned SW = cr_interp_pkg::SEG_WIDTH;
  localparam int unsigned SF = cr_interp_pkg::S_FRAC;
  // Coefficients need five extra bits, the accumulator adds the s fraction.
  localparam int unsigned CW = W + 5;
  localparam int unsigned AW = CW + SF;
  localparam int unsigned MW = (CW > SF + 1) ? CW : SF + 1;
  localparam int unsigned PW = MW + SF + 1;

  localparam logic [SW-1:0] SegMax   = SW'(MAX_SEGMENTS);
  localparam logic [SW-1:0] SegReset =
      SW'((MAX_SEGMENTS < cr_interp_pkg::SEG_RESET) ? MAX_SEGMENTS : cr_interp_pkg::SEG_RESET);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_LOAD  = 7'b0000010,
    ST_LO    = 7'b0000100,
    ST_HI    = 7'b0001000,
    ST_RND   = 7'b0010000,
    ST_EMIT  = 7'b0100000,
    ST_POINT = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [SW-1:0]        seg_q;
  logic signed [W-1:0]  hx_q [3];
  logic signed [W-1:0]  hy_q [3];
  logic [1:0]           ps_q;
  logic signed [W-1:0]  px_q [4];
  logic signed [W-1:0]  py_q [4];
  logic signed [W-1:0]  cx_q, cy_q;
  logic                 fin_q;
  logic                 span_b_q;
  logic [SW-1:0]        t_q;
  logic [SF:0]          s_q;
  logic [SW-1:0]        r_q;
  logic [SF:0]          step_q_q;
  logic [SW-1:0]        step_r_q;
  logic                 coord_q;
  logic [1:0]           round_q;
  logic [AW-1:0]        acc_q;
  logic [SF:0]          plo_q;
  logic signed [W-1:0]  res_x_q, res_y_q;
  logic                 out_valid_q;
  logic signed [W-1:0]  out_x_q, out_y_q;
  logic                 out_last_q;

  // --------------------------------------------------------------------------
  // Handshakes and input fields.
  // --------------------------------------------------------------------------
  logic                accept;
  logic                out_free;
  logic signed [W-1:0] in_x, in_y;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign in_x          = s_axis_tdata[W-1:0];
  assign in_y          = s_axis_tdata[2*W-1:W];

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = DataWidth'({out_y_q, out_x_q});
  assign m_axis_tlast  = out_last_q;

  // --------------------------------------------------------------------------
  // Segment count write, clamped into 1 .. MAX_SEGMENTS.
  // --------------------------------------------------------------------------
  logic [SW-1:0] seg_wr;

  always_comb begin
    seg_wr = cfg_data_i;
    if (cfg_data_i == '0) begin
      seg_wr = SW'(1);
    end else if (cfg_data_i > SegMax) begin
      seg_wr = SegMax;
    end
  end

  // Step of s per sample: 65536 / n as quotient and remainder.
  logic [SF:0]     step_quot;
  logic [SF+SW:0]  step_prod;
  logic [SF+SW:0]  step_rem;

  assign step_quot = cr_interp_pkg::SEG_STEP[seg_q];
  assign step_prod = (SF+SW+1)'(step_quot) * (SF+SW+1)'(seg_q);
  assign step_rem  = ((SF+SW+1)'(1) << SF) - step_prod;

  // Next sample position: s advances by the quotient, the remainder carries.
  logic [SW:0]   r_sum;
  logic          r_wrap;
  logic [SW:0]   r_wrapped;
  logic [SW-1:0] r_next;
  logic [SF:0]   s_next;
  logic          t_last;

  assign r_sum     = {1'b0, r_q} + {1'b0, step_r_q};
  assign r_wrap    = r_sum >= {1'b0, seg_q};
  assign r_wrapped = r_sum - {1'b0, seg_q};
  assign r_next    = r_wrap ? r_wrapped[SW-1:0] : r_sum[SW-1:0];
  assign s_next    = s_q + step_q_q + (SF+1)'(r_wrap);
  assign t_last    = (t_q == seg_q - SW'(1));

  // --------------------------------------------------------------------------
  // Cubic coefficients of the coordinate being worked on.
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] p0, p1, p2, p3;
  logic signed [CW-1:0] d12;
  logic signed [CW-1:0] coef_a, coef_b, coef_c, coef_d;
  logic signed [CW-1:0] addend;

  always_comb begin
    if (coord_q) begin
      p0 = CW'(py_q[0]);
      p1 = CW'(py_q[1]);
      p2 = CW'(py_q[2]);
      p3 = CW'(py_q[3]);
    end else begin
      p0 = CW'(px_q[0]);
      p1 = CW'(px_q[1]);
      p2 = CW'(px_q[2]);
      p3 = CW'(px_q[3]);
    end
  end

  assign d12    = p1 - p2;
  assign coef_a = p2 - p0;
  assign coef_b = (p0 <<< 1) - (p1 + (p1 <<< 2)) + (p2 <<< 2) - p3;
  assign coef_c = (p3 - p0) + d12 + (d12 <<< 1);
  assign coef_d = p1 <<< 1;

  // Horner order: c*s + b, then *s + a, then *s + 2*p1.
  always_comb begin
    case (round_q)
      2'd0:    addend = coef_b;
      2'd1:    addend = coef_a;
      default: addend = coef_d;
    endcase
  end

  // --------------------------------------------------------------------------
  // Shared multiplier. The accumulator times s is split into its low 16 bits
  // (rounded product kept in plo_q) and its high part, one pass each.
  // --------------------------------------------------------------------------
  logic signed [MW-1:0] mul_a;
  logic signed [SF:0]   mul_b;
  logic signed [PW-1:0] prod;
  logic [2*SF:0]        lo_sum;
  logic [SF:0]          plo_d;
  logic [AW-1:0]        acc_next;

  always_comb begin
    if (state_q == ST_LO) begin
      mul_a = signed'(MW'(acc_q[SF-1:0]));
    end else begin
      mul_a = MW'(signed'(acc_q[AW-1:SF]));
    end
  end

  assign mul_b    = signed'({1'b0, s_q[SF-1:0]});
  assign prod     = mul_a * mul_b;
  assign lo_sum   = {1'b0, prod[2*SF-1:0]} + ((2*SF+1)'(1) << (SF - 1));
  assign plo_d    = lo_sum[2*SF:SF];
  assign acc_next = {addend, {SF{1'b0}}} + prod[AW-1:0] + AW'(plo_q);

  // Halve and drop to Q8.8 with rounding, then saturate to the coordinate range.
  logic [AW-1:0]       rnd_sum;
  logic [W+3:0]        rnd_val;
  logic [4:0]          rnd_top;
  logic signed [W-1:0] rnd_sat;

  assign rnd_sum = acc_q + (AW'(1) << SF);
  assign rnd_val = rnd_sum[AW-1:SF+1];
  assign rnd_top = rnd_val[W+3:W-1];

  always_comb begin
    if ((&rnd_top) || !(|rnd_top)) begin
      rnd_sat = rnd_val[W-1:0];
    end else if (rnd_val[W+3]) begin
      rnd_sat = {1'b1, {(W-1){1'b0}}};
    end else begin
      rnd_sat = {1'b0, {(W-1){1'b1}}};
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer.
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (ps_q[1]) begin
            state_d = ST_LOAD;
          end else if (s_axis_tlast) begin
            state_d = (ps_q == 2'd1) ? ST_LOAD : ST_POINT;
          end
        end
      end
      ST_LOAD: state_d = ST_LO;
      ST_LO:   state_d = ST_HI;
      ST_HI:   state_d = (round_q == 2'd2) ? ST_RND : ST_LO;
      ST_RND:  state_d = coord_q ? ST_EMIT : ST_LOAD;
      ST_EMIT: begin
        if (out_free) begin
          if (!t_last || span_b_q) begin
            state_d = ST_LOAD;
          end else begin
            state_d = fin_q ? ST_POINT : ST_IDLE;
          end
        end
      end
      ST_POINT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seg_q       <= SegReset;
      ps_q        <= 2'd0;
      span_b_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        seg_q <= seg_wr;
      end
      if (accept) begin
        span_b_q <= s_axis_tlast && ps_q[1];
        if (s_axis_tlast) begin
          ps_q <= 2'd0;
        end else if (ps_q != 2'd3) begin
          ps_q <= ps_q + 2'd1;
        end
      end else if (state_q == ST_EMIT && out_free && t_last) begin
        span_b_q <= 1'b0;
      end
      if ((state_q == ST_EMIT || state_q == ST_POINT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cx_q     <= in_x;
      cy_q     <= in_y;
      fin_q    <= s_axis_tlast;
      t_q      <= '0;
      s_q      <= '0;
      r_q      <= seg_q >> 1;
      coord_q  <= 1'b0;
      step_q_q <= step_quot;
      step_r_q <= step_rem[SW-1:0];
      if (ps_q[1]) begin
        // Inner span; the first one reuses p1 as p0.
        px_q[0] <= ps_q[0] ? hx_q[2] : hx_q[1];
        py_q[0] <= ps_q[0] ? hy_q[2] : hy_q[1];
        px_q[1] <= hx_q[1];
        py_q[1] <= hy_q[1];
        px_q[2] <= hx_q[0];
        py_q[2] <= hy_q[0];
        px_q[3] <= in_x;
        py_q[3] <= in_y;
      end else begin
        // Closing span of a two-point curve.
        px_q[0] <= hx_q[0];
        py_q[0] <= hy_q[0];
        px_q[1] <= hx_q[0];
        py_q[1] <= hy_q[0];
        px_q[2] <= in_x;
        py_q[2] <= in_y;
        px_q[3] <= in_x;
        py_q[3] <= in_y;
      end
      if (!s_axis_tlast) begin
        hx_q[2] <= hx_q[1];
        hy_q[2] <= hy_q[1];
        hx_q[1] <= hx_q[0];
        hy_q[1] <= hy_q[0];
        hx_q[0] <= in_x;
        hy_q[0] <= in_y;
      end
    end

    unique case (state_q)
      ST_LOAD: begin
        acc_q   <= {coef_c, {SF{1'b0}}};
        round_q <= 2'd0;
      end
      ST_LO: begin
        plo_q <= plo_d;
      end
      ST_HI: begin
        acc_q   <= acc_next;
        round_q <= round_q + 2'd1;
      end
      ST_RND: begin
        if (coord_q) begin
          res_y_q <= rnd_sat;
        end else begin
          res_x_q <= rnd_sat;
          coord_q <= 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_x_q    <= res_x_q;
          out_y_q    <= res_y_q;
          out_last_q <= t_last && !fin_q;
          coord_q    <= 1'b0;
          if (!t_last) begin
            t_q <= t_q + SW'(1);
            s_q <= s_next;
            r_q <= r_next;
          end else if (span_b_q) begin
            // The closing span is the inner span shifted by one point.
            px_q[0] <= px_q[1];
            py_q[0] <= py_q[1];
            px_q[1] <= px_q[2];
            py_q[1] <= py_q[2];
            px_q[2] <= px_q[3];
            py_q[2] <= py_q[3];
            t_q     <= '0;
            s_q     <= '0;
            r_q     <= seg_q >> 1;
          end
        end
      end
      ST_POINT: begin
        if (out_free) begin
          out_x_q    <= cx_q;
          out_y_q    <= cy_q;
          out_last_q <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/cr_interp_checker.sv =====
// ============================================================================
// cr_interp_checker: port-level checks for the curve interpolator
// Watches both streams of the top level and flags handshake and sequencing
// slips; attached to the top level by the bind statement below.
// ============================================================================
`default_nettype none

module cr_interp_checker #(
  parameter int unsigned COORD_WIDTH = cr_interp_pkg::DEFAULT_COORD_WIDTH,
  localparam int unsigned DataWidth  = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 s_axis_tlast,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [DataWidth-1:0] m_axis_tdata,
  input logic                 m_axis_tlast
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result payload changed while stalled");

  // A final point always produces work, so the block is busy right after it.
  a_final_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("ready right after a final point");

  // While a run is still open the block takes no new point.
  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("ready while a run of results is open");

endmodule

bind catmull_rom_curve_interpolator_unit cr_interp_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_cr_interp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== bench/tb_catmull_rom_curve_interpolator_unit.sv =====
// ============================================================================
// tb_catmull_rom_curve_interpolator_unit: self-checking bench for the spline unit
// Streams control points into the interpolator, predicts every curve sample
// in fixed point and compares each output transfer with the oldest pending
// sample. A directed table comes first, then random curves under three idle
// patterns and one long output stall.
// ============================================================================
`default_nettype none

module tb_catmull_rom_curve_interpolator_unit;

  // One curve sample as it leaves the block.
  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic        last;
  } sample_t;

  // How a directed row is checked, or whether it is a register write.
  typedef enum logic [1:0] {
    ROW_PREDICT,  // checked against the predictor
    ROW_SILENT,   // must produce no sample at all
    ROW_ECHO,     // lone final point: one sample equal to the point itself
    ROW_SEGS      // write the segment count register
  } row_kind_e;

  typedef struct packed {
    row_kind_e                           kind;
    logic [15:0]                         x;
    logic [15:0]                         y;
    logic                                fin;
    logic [cr_interp_pkg::SEG_WIDTH-1:0] segs;
  } dir_row_t;

  localparam int DIR_N          = 24;
  localparam int ITEMS_PER_PASS = 116;
  localparam int HOLD_CYCLES    = 900;
  localparam int SETTLE_CYCLES  = 8;

  // Directed stimulus. Rows 0..9 run with the reset segment count of eight.
  localparam dir_row_t DIRECTED [DIR_N] = '{
    '{ROW_ECHO,    16'h7FFF, 16'h8000, 1'b1, 5'd0},
    '{ROW_ECHO,    16'h8000, 16'h7FFF, 1'b1, 5'd0},
    '{ROW_ECHO,    16'h0000, 16'h0000, 1'b1, 5'd0},
    '{ROW_SILENT,  16'h0100, 16'h0200, 1'b0, 5'd0},
    '{ROW_PREDICT, 16'h0300, 16'hFF00, 1'b1, 5'd0},
    '{ROW_SILENT,  16'h7FFF, 16'h7FFF, 1'b0, 5'd0},
    '{ROW_SILENT,  16'h8000, 16'h8000, 1'b0, 5'd0},
    '{ROW_PREDICT, 16'h7FFF, 16'h8000, 1'b0, 5'd0},
    '{ROW_PREDICT, 16'h8000, 16'h7FFF, 1'b0, 5'd0},
    '{ROW_PREDICT, 16'h1234, 16'hEDCC, 1'b1, 5'd0},
    '{ROW_SEGS,    16'h0000, 16'h0000, 1'b0, 5'd0},
    '{ROW_SILENT,  16'h0080, 16'hFF80, 1'b0, 5'd0},
    '{ROW_PREDICT, 16'h0500, 16'hFB00, 1'b1, 5'd0},
    '{ROW_SEGS,    16'h0000, 16'h0000, 1'b0, 5'd31},
    '{ROW_SILENT,  16'h4000, 16'hC000, 1'b0, 5'd0},
    '{ROW_SILENT,  16'hC000, 16'h4000, 1'b0, 5'd0},
    '{ROW_PREDICT, 16'h7FFF, 16'h7FFF, 1'b0, 5'd0},
    '{ROW_PREDICT, 16'h8000, 16'h8000, 1'b0, 5'd0},
    '{ROW_PREDICT, 16'hFFFF, 16'h0001, 1'b1, 5'd0},
    '{ROW_SEGS,    16'h0000, 16'h0000, 1'b0, 5'd16},
    '{ROW_SILENT,  16'h0001, 16'hFFFF, 1'b0, 5'd0},
    '{ROW_SILENT,  16'hFFFF, 16'h0001, 1'b0, 5'd0},
    '{ROW_PREDICT, 16'h0000, 16'h0000, 1'b1, 5'd0},
    '{ROW_SEGS,    16'h0000, 16'h0000, 1'b0, 5'd2}
  };

  // DUT ports. Every input is known from time zero.
  logic                                clk_i         = 1'b0;
  logic                                rst_ni        = 1'b0;
  logic                                cfg_we_i      = 1'b0;
  logic [cr_interp_pkg::SEG_WIDTH-1:0] cfg_data_i    = '0;
  logic                                s_axis_tvalid = 1'b0;
  logic                                s_axis_tready;
  logic [31:0]                         s_axis_tdata  = '0;  // point_x, point_y
  logic                                s_axis_tlast  = 1'b0;  // final_point
  logic                                m_axis_tvalid;
  logic                                m_axis_tready = 1'b0;
  logic [31:0]                         m_axis_tdata;  // curve_x, curve_y
  logic                                m_axis_tlast;  // run_end

  // Predictor state: control point history (entry 0 newest), how many points
  // of the current curve have been seen, and the stored segment count.
  longint hist_x [3];
  longint hist_y [3];
  int     pts_seen;
  int     segs;

  // Samples predicted for accepted points and not yet seen on the output.
  sample_t pending_samples [$];

  // Idle percentages of both sides and the long output hold-off request.
  int   src_gap_pct = 0;
  int   dst_gap_pct = 0;
  logic hold_toggle = 1'b0;
  logic hold_seen   = 1'b0;
  int   hold_left   = 0;

  int err_count     = 0;
  int points_sent   = 0;
  int curves_sent   = 0;
  int samples_seen  = 0;
  int seg_writes    = 0;

  catmull_rom_curve_interpolator_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Guard against a hung handshake.
  initial begin
    #30_000_000;
    $display("FAILURE");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Fixed-point spline arithmetic
  // --------------------------------------------------------------------------

  // v * s / 2^16 rounded to nearest, ties up; split so the product stays small.
  function automatic longint mul_frac(longint v, longint s);
    longint hi, lo;
    hi = v >>> 16;
    lo = v - hi * 65536;
    return hi * s + ((lo * s + 32768) >>> 16);
  endfunction

  // One coordinate of the cubic at parameter s (Q0.16), back in saturated Q8.8.
  function automatic logic [15:0] cubic_at(longint p0, longint p1, longint p2, longint p3,
                                           longint s);
    longint a, b, c, u, r;
    a = (p2 - p0) * 65536;
    b = (2 * p0 - 5 * p1 + 4 * p2 - p3) * 65536;
    c = (-p0 + 3 * p1 - 3 * p2 + p3) * 65536;
    u = b + mul_frac(c, s);
    u = a + mul_frac(u, s);
    u = 2 * p1 * 65536 + mul_frac(u, s);
    // Halve and drop the extra fraction bits in one rounded shift.
    r = (u + 65536) >>> 17;
    if (r > 32767) r = 32767;
    else if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  // Queues the samples of one span between control points p1 and p2.
  function automatic void push_span(longint x0, longint x1, longint x2, longint x3,
                                    longint y0, longint y1, longint y2, longint y3,
                                    bit keep);
    longint s;
    sample_t smp;
    for (int t = 0; t < segs; t++) begin
      s = (longint'(t) * 65536 + segs / 2) / segs;
      smp.x    = cubic_at(x0, x1, x2, x3, s);
      smp.y    = cubic_at(y0, y1, y2, y3, s);
      smp.last = 1'b0;
      if (keep) pending_samples.push_back(smp);
    end
  endfunction

  // Advances the predictor by one accepted control point. With keep set the
  // predicted samples are queued; otherwise only the history moves on.
  function automatic void predict_curve_point(logic [15:0] xr, logic [15:0] yr, logic fin,
                                              bit keep);
    longint  cx, cy;
    int      k;
    int      n;
    sample_t smp;
    cx = longint'($signed(xr));
    cy = longint'($signed(yr));
    n  = 0;
    // The span between the two previous points; the first span of a curve
    // reuses its start point as the point before it.
    if (pts_seen >= 2) begin
      k = (pts_seen >= 3) ? 2 : 1;
      push_span(hist_x[k], hist_x[1], hist_x[0], cx, hist_y[k], hist_y[1], hist_y[0], cy, keep);
      n += segs;
    end
    if (fin) begin
      // Closing span reuses the final point as the point after it.
      if (pts_seen >= 1) begin
        k = (pts_seen >= 2) ? 1 : 0;
        push_span(hist_x[k], hist_x[0], cx, cx, hist_y[k], hist_y[0], cy, cy, keep);
        n += segs;
      end
      smp.x    = xr;
      smp.y    = yr;
      smp.last = 1'b0;
      if (keep) pending_samples.push_back(smp);
      n++;
      for (int i = 0; i < 3; i++) begin
        hist_x[i] = 0;
        hist_y[i] = 0;
      end
      pts_seen = 0;
    end else begin
      hist_x[2] = hist_x[1];
      hist_x[1] = hist_x[0];
      hist_x[0] = cx;
      hist_y[2] = hist_y[1];
      hist_y[1] = hist_y[0];
      hist_y[0] = cy;
      if (pts_seen < 3) pts_seen++;
    end
    if (keep && n > 0) pending_samples[pending_samples.size() - 1].last = 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Offers one control point after a random gap and waits for its transfer.
  // The expected samples are queued at the edge that completes the transfer.
  task automatic put_point(input logic [15:0] x, input logic [15:0] y, input logic fin,
                           input row_kind_e kind);
    sample_t smp;
    while ($urandom_range(99) < src_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {y, x};
    s_axis_tlast  <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    case (kind)
      ROW_SILENT: predict_curve_point(x, y, fin, 1'b0);
      ROW_ECHO: begin
        predict_curve_point(x, y, fin, 1'b0);
        smp.x    = x;
        smp.y    = y;
        smp.last = 1'b1;
        pending_samples.push_back(smp);
      end
      default: predict_curve_point(x, y, fin, 1'b1);
    endcase
    points_sent++;
    if (fin) curves_sent++;
  endtask

  // Stops offering points, waits for every pending sample and lets the
  // sequencer settle, so the block is idle afterwards.
  task automatic drain_block();
    s_axis_tvalid <= 1'b0;
    for (int w = 0; w < 200000 && pending_samples.size() != 0; w++) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes the segment count register while the block is idle.
  task automatic write_segments(input logic [cr_interp_pkg::SEG_WIDTH-1:0] value);
    drain_block();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    // Zero is stored as one, anything past the maximum as the maximum.
    segs = (value < 1) ? 1 : int'(value);
    if (segs > cr_interp_pkg::DEFAULT_MAX_SEGMENTS) segs = cr_interp_pkg::DEFAULT_MAX_SEGMENTS;
    seg_writes++;
  endtask

  // Coordinates: mostly moderate values, some full-range noise and extremes
  // that drive the cubic into saturation.
  function automatic logic [15:0] pick_coord();
    int mode;
    mode = $urandom_range(9);
    case (mode)
      0: begin
        case ($urandom_range(3))
          0:       return 16'h7FFF;
          1:       return 16'h8000;
          2:       return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
      1, 2, 3, 4: return 16'($urandom);
      default: return 16'($signed($urandom_range(8191)) - 4096);
    endcase
  endfunction

  // Segment counts favor small values; the extremes and clamped writes
  // above the maximum show up now and then.
  function automatic logic [cr_interp_pkg::SEG_WIDTH-1:0] pick_segments();
    case ($urandom_range(9))
      0:       return 5'd0;
      1:       return 5'($urandom_range(31, 17));
      2:       return 5'd16;
      default: return 5'($urandom_range(6, 1));
    endcase
  endfunction

  task automatic run_curve(input int npts);
    for (int i = 0; i < npts; i++)
      put_point(pick_coord(), pick_coord(), (i == npts - 1), ROW_PREDICT);
  endtask

  // --------------------------------------------------------------------------
  // Output side: ready pattern, long hold-off, and the sample check
  // --------------------------------------------------------------------------

  // A toggle of hold_toggle starts a long stretch with ready low; the count
  // runs here so the sender keeps offering points meanwhile.
  always @(posedge clk_i) begin
    if (hold_toggle != hold_seen) begin
      hold_seen     <= hold_toggle;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= dst_gap_pct);
    end
  end

  // Every output transfer is matched against the oldest pending sample.
  always @(posedge clk_i) begin
    sample_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tlast};
      samples_seen++;
      if (pending_samples.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("Unexpected sample x=%h y=%h last=%b", got.x, got.y, got.last);
      end else begin
        want = pending_samples.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.last !== want.last) begin
          err_count++;
          if (err_count <= 10)
            $display("Sample mismatch: expected x=%h y=%h last=%b, got x=%h y=%h last=%b",
                     want.x, want.y, want.last, got.x, got.y, got.last);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    dir_row_t row;
    int       target;

    for (int i = 0; i < 3; i++) begin
      hist_x[i] = 0;
      hist_y[i] = 0;
    end
    pts_seen = 0;
    segs     = cr_interp_pkg::SEG_RESET;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table, sender lightly idle and receiver heavily idle.
    src_gap_pct <= 7;
    dst_gap_pct <= 86;
    for (int r = 0; r < DIR_N; r++) begin
      row = DIRECTED[r];
      if (row.kind == ROW_SEGS) write_segments(row.segs);
      else put_point(row.x, row.y, row.fin, row.kind);
    end

    // Three passes of random curves, each with its own idle pattern.
    for (int pass = 0; pass < 3; pass++) begin
      case (pass)
        0: begin
          src_gap_pct <= 7;
          dst_gap_pct <= 86;
        end
        1: begin
          src_gap_pct <= 86;
          dst_gap_pct <= 7;
        end
        default: begin
          src_gap_pct <= 0;
          dst_gap_pct <= 0;
        end
      endcase

      if (pass == 0) begin
        // Back pressure: the output holds off for a long stretch while points
        // keep coming, so the block fills and drops its input ready.
        write_segments(5'd4);
        src_gap_pct <= 0;
        hold_toggle <= ~hold_toggle;
        run_curve(8);
        src_gap_pct <= 7;
      end

      target = DIR_N + (pass + 1) * ITEMS_PER_PASS;
      while (points_sent < target) begin
        if ($urandom_range(2) == 0) write_segments(pick_segments());
        // Mostly real curves; short one- and two-point curves are the noise.
        if ($urandom_range(4) == 0) run_curve($urandom_range(2, 1));
        else run_curve($urandom_range(8, 3));
      end
    end

    drain_block();
    repeat (40) @(posedge clk_i);
    if (pending_samples.size() != 0) begin
      err_count++;
      $display("%0d expected samples never arrived", pending_samples.size());
    end

    $display("Sent %0d control points in %0d curves with %0d segment count writes.",
             points_sent, curves_sent, seg_writes);
    $display("Checked %0d curve samples under three idle patterns and one long stall; %0d errors.",
             samples_seen, err_count);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
